### rtl/tcce_pkg.sv
// shared types, character codes and reset values for the text console character engine
package tcce_pkg;

  // tab expansion and per-byte result limit
  localparam int unsigned TAB_SPACES_DEF = 4;
  localparam int unsigned MAX_RESULTS    = 8;
  localparam int unsigned CNT_W          = $clog2(MAX_RESULTS + 1);

  // result kinds
  typedef enum logic [1:0] {
    KIND_DRAW   = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_BADESC = 2'd2
  } kind_t;

  // character codes
  localparam logic [7:0] CH_BS          = 8'h08;
  localparam logic [7:0] CH_TAB         = 8'h09;
  localparam logic [7:0] CH_LF          = 8'h0A;
  localparam logic [7:0] CH_CR          = 8'h0D;
  localparam logic [7:0] CH_ESC         = 8'h1B;
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] CH_DIGIT_0     = 8'h30;
  localparam logic [7:0] CH_DIGIT_9     = 8'h39;
  localparam logic [7:0] CH_UPPER_A     = 8'h41;
  localparam logic [7:0] CH_UPPER_F     = 8'h46;
  localparam logic [7:0] CH_LOWER_B     = 8'h62;
  localparam logic [7:0] CH_LOWER_F     = 8'h66;
  localparam logic [7:0] HEX_ALPHA_BASE = CH_UPPER_A - 8'd10;

  // configuration register indexes
  localparam logic [3:0] REG_TEXT_COLUMNS = 4'd0;
  localparam logic [3:0] REG_TEXT_ROWS    = 4'd1;
  localparam logic [3:0] REG_GLYPH_WIDTH  = 4'd2;
  localparam logic [3:0] REG_GLYPH_HEIGHT = 4'd3;
  localparam logic [3:0] REG_MARGIN_X     = 4'd4;
  localparam logic [3:0] REG_MARGIN_Y     = 4'd5;
  localparam logic [3:0] REG_DEFAULT_FG   = 4'd6;
  localparam logic [3:0] REG_DEFAULT_BG   = 4'd7;

  // configuration registers
  typedef struct packed {
    logic [9:0]  text_columns;
    logic [8:0]  text_rows;
    logic [5:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic [4:0]  margin_x;
    logic [4:0]  margin_y;
    logic [31:0] default_fg;
    logic [31:0] default_bg;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    text_columns: 10'd80,
    text_rows:    9'd25,
    glyph_width:  6'd8,
    glyph_height: 6'd16,
    margin_x:     5'd0,
    margin_y:     5'd0,
    default_fg:   32'h00FF_FFFF,
    default_bg:   32'h0000_0000
  };

  // console state carried from step to step
  typedef struct packed {
    logic [9:0]       col;
    logic [8:0]       row;
    logic [31:0]      fg;
    logic [31:0]      bg;
    logic             esc;
    logic             edit_bg;
    logic             tab_act;
    logic             scroll_pend;
    logic [CNT_W-1:0] cnt;
  } eng_state_t;

  localparam eng_state_t ST_RESET = '{
    col:         10'd0,
    row:         9'd0,
    fg:          32'h00FF_FFFF,
    bg:          32'h0000_0000,
    esc:         1'b0,
    edit_bg:     1'b0,
    tab_act:     1'b0,
    scroll_pend: 1'b0,
    cnt:         '0
  };

  // one result transaction
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  glyph;
    logic [13:0] px;
    logic [12:0] py;
    logic [31:0] fg;
    logic [31:0] bg;
    logic        last;
  } result_t;

endpackage

### rtl/tcce_step.sv
// one console step: next cursor and color state and at most one result
module tcce_step #(
  parameter int unsigned TAB_SPACES = tcce_pkg::TAB_SPACES_DEF,
  parameter int unsigned SL_W       = 2
) (
  input  tcce_pkg::cfg_t       cfg_i,
  input  tcce_pkg::eng_state_t st_i,
  input  logic [7:0]           char_i,
  input  logic [SL_W-1:0]      sl_i,
  output tcce_pkg::eng_state_t st_o,
  output logic [SL_W-1:0]      sl_o,
  output tcce_pkg::result_t    res_o,
  output logic                 emit_o,
  output logic                 done_o
);
  import tcce_pkg::*;

  logic            eff_tab;
  logic [SL_W-1:0] rem;
  logic [7:0]      ch;
  logic [15:0]     px_full;
  logic [14:0]     py_full;
  logic [8:0]      row_sat;
  logic            is_dec;
  logic            is_alpha;
  logic [3:0]      nib;

  // a tab in normal mode runs as a series of spaces
  assign eff_tab = st_i.tab_act || ((char_i == CH_TAB) && !st_i.esc);
  assign rem     = st_i.tab_act ? sl_i : (eff_tab ? SL_W'(TAB_SPACES - 1) : '0);
  assign ch      = eff_tab ? CH_SPACE : char_i;

  // glyph cell position of the current cursor
  assign px_full = 16'({6'd0, st_i.col} * {10'd0, cfg_i.glyph_width}) + {11'd0, cfg_i.margin_x};
  assign py_full = 15'({6'd0, st_i.row} * {9'd0, cfg_i.glyph_height}) + {10'd0, cfg_i.margin_y};

  // row left after a scroll
  assign row_sat = (cfg_i.text_rows == 9'd0) ? 9'd0 : cfg_i.text_rows - 9'd1;

  // hex digit decode for escape color entry
  assign is_dec   = (char_i >= CH_DIGIT_0) && (char_i <= CH_DIGIT_9);
  assign is_alpha = (char_i >= CH_UPPER_A) && (char_i <= CH_UPPER_F);
  assign nib      = is_dec ? 4'(char_i - CH_DIGIT_0) : 4'(char_i - HEX_ALPHA_BASE);

  always_comb begin
    logic [10:0] col_new;
    logic [9:0]  row_new;
    logic        wrap;
    logic [9:0]  col_w;
    logic [9:0]  row_w;
    logic        sc;
    logic        draw;
    logic        emit_raw;
    logic        final_res;

    st_o      = st_i;
    sl_o      = sl_i;
    res_o     = '0;
    emit_raw  = 1'b0;
    final_res = 1'b0;
    done_o    = 1'b0;
    col_new   = {1'b0, st_i.col};
    row_new   = {1'b0, st_i.row};
    draw      = 1'b0;
    wrap      = 1'b0;
    col_w     = st_i.col;
    row_w     = {1'b0, st_i.row};
    sc        = 1'b0;

    if (st_i.scroll_pend) begin
      // scroll after the cursor moves past the bottom row
      emit_raw          = 1'b1;
      res_o.kind        = KIND_SCROLL;
      st_o.row          = row_sat;
      st_o.scroll_pend  = 1'b0;
      if (st_i.tab_act && (sl_i != '0)) begin
        sl_o = sl_i - SL_W'(1);
      end else begin
        done_o       = 1'b1;
        final_res    = 1'b1;
        st_o.tab_act = 1'b0;
      end
    end else if (st_i.esc) begin
      // escape sequence bytes
      done_o = 1'b1;
      if (char_i == CH_ESC) begin
        st_o.esc = 1'b0;
      end else if (char_i == CH_LOWER_F) begin
        st_o.edit_bg = 1'b0;
        st_o.fg      = '0;
      end else if (char_i == CH_LOWER_B) begin
        st_o.edit_bg = 1'b1;
        st_o.bg      = '0;
      end else if (is_dec || is_alpha) begin
        if (st_i.edit_bg) begin
          st_o.bg = {st_i.bg[27:0], nib};
        end else begin
          st_o.fg = {st_i.fg[27:0], nib};
        end
      end else begin
        if (st_i.edit_bg) begin
          st_o.bg = cfg_i.default_bg;
        end else begin
          st_o.fg = cfg_i.default_fg;
        end
        st_o.esc    = 1'b0;
        emit_raw    = 1'b1;
        final_res   = 1'b1;
        res_o.kind  = KIND_BADESC;
        res_o.glyph = char_i;
      end
    end else if (ch == CH_ESC) begin
      st_o.esc = 1'b1;
      done_o   = 1'b1;
    end else begin
      // cursor movement for plain bytes
      case (ch)
        CH_LF: begin
          col_new = 11'd0;
          row_new = {1'b0, st_i.row} + 10'd1;
        end
        CH_CR: begin
          col_new = 11'd0;
        end
        CH_BS: begin
          if (st_i.col == 10'd0) begin
            if (st_i.row != 9'd0) begin
              col_new = {1'b0, cfg_i.text_columns - 10'd1};
              row_new = {1'b0, st_i.row} - 10'd1;
            end
          end else begin
            col_new = {1'b0, st_i.col} - 11'd1;
          end
        end
        default: begin
          draw    = 1'b1;
          col_new = {1'b0, st_i.col} + 11'd1;
        end
      endcase

      // wrap at the right edge, then check the bottom
      wrap  = col_new >= {1'b0, cfg_i.text_columns};
      col_w = wrap ? 10'd0 : col_new[9:0];
      row_w = row_new + {9'd0, wrap};
      sc    = row_w >= {1'b0, cfg_i.text_rows};

      emit_raw    = draw;
      res_o.kind  = KIND_DRAW;
      res_o.glyph = draw ? ch : 8'd0;
      res_o.px    = draw ? px_full[13:0] : 14'd0;
      res_o.py    = draw ? py_full[12:0] : 13'd0;
      st_o.col    = col_w;
      st_o.row    = row_w[8:0];

      if (sc) begin
        st_o.scroll_pend = 1'b1;
        st_o.tab_act     = eff_tab;
        sl_o             = rem;
      end else if (rem != '0) begin
        st_o.tab_act = 1'b1;
        sl_o         = rem - SL_W'(1);
      end else begin
        done_o       = 1'b1;
        final_res    = draw;
        st_o.tab_act = 1'b0;
      end
    end

    // results past the per-byte limit are dropped
    emit_o     = emit_raw && (st_i.cnt < CNT_W'(MAX_RESULTS));
    res_o.last = final_res || (st_i.cnt == CNT_W'(MAX_RESULTS - 1));
    res_o.fg   = st_o.fg;
    res_o.bg   = st_o.bg;
    if (done_o) begin
      st_o.cnt = '0;
    end else if (emit_o) begin
      st_o.cnt = st_i.cnt + CNT_W'(1);
    end
  end

endmodule

### rtl/text_console_char_engine_top.sv
// top level of the text console character engine
// Takes one console byte per transaction and gives draw, scroll and bad-escape results,
// one result per cycle through a registered output stage unless out_ready stalls it.
// An ordinary byte or escape byte takes one step, and the next byte is taken in the
// same cycle the current one finishes. A byte that pushes the cursor past the bottom
// row takes one extra step for its scroll result. A tab runs as TAB_SPACES space steps
// plus one per scroll it causes. At most eight results come from one byte; later ones are
// dropped, and the eighth is marked last. The user must write configuration through
// the cfg port only while the engine is idle; the block itself does not enforce it.
module text_console_char_engine_top #(
  parameter int unsigned TAB_SPACES = tcce_pkg::TAB_SPACES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_glyph,
  output logic [13:0] out_pixel_x,
  output logic [12:0] out_pixel_y,
  output logic [31:0] out_fg_color,
  output logic [31:0] out_bg_color,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tcce_pkg::*;

  localparam int unsigned SL_W = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

  cfg_t            cfg_r;
  eng_state_t      st_r;
  eng_state_t      st_nxt;
  logic [SL_W-1:0] sl_r;
  logic [SL_W-1:0] sl_nxt;
  logic            cur_valid_r;
  logic [7:0]      cur_char_r;
  logic            out_valid_r;
  result_t         out_res_r;
  result_t         res;
  logic            emit;
  logic            done;
  logic            out_free;
  logic            step_go;
  logic            step_done;
  logic            in_fire;

  // step logic
  tcce_step #(
    .TAB_SPACES (TAB_SPACES),
    .SL_W       (SL_W)
  ) u_step (
    .cfg_i  (cfg_r),
    .st_i   (st_r),
    .char_i (cur_char_r),
    .sl_i   (sl_r),
    .st_o   (st_nxt),
    .sl_o   (sl_nxt),
    .res_o  (res),
    .emit_o (emit),
    .done_o (done)
  );

  // handshake control
  assign out_free  = !out_valid_r || out_ready;
  assign step_go   = cur_valid_r && out_free;
  assign step_done = step_go && done;
  assign in_ready  = !cur_valid_r || step_done;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEXT_COLUMNS: cfg_r.text_columns <= cfg_data[9:0];
        REG_TEXT_ROWS:    cfg_r.text_rows    <= cfg_data[8:0];
        REG_GLYPH_WIDTH:  cfg_r.glyph_width  <= cfg_data[5:0];
        REG_GLYPH_HEIGHT: cfg_r.glyph_height <= cfg_data[5:0];
        REG_MARGIN_X:     cfg_r.margin_x     <= cfg_data[4:0];
        REG_MARGIN_Y:     cfg_r.margin_y     <= cfg_data[4:0];
        REG_DEFAULT_FG:   cfg_r.default_fg   <= cfg_data;
        REG_DEFAULT_BG:   cfg_r.default_bg   <= cfg_data;
        default: ;
      endcase
    end
  end

  // console state, input holding register and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RESET;
      sl_r        <= '0;
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step_go) begin
        st_r <= st_nxt;
        sl_r <= sl_nxt;
      end
      if (in_fire) begin
        cur_valid_r <= 1'b1;
      end else if (step_done) begin
        cur_valid_r <= 1'b0;
      end
      if (step_go && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_char_r <= in_char_code;
    end
    if (step_go && emit) begin
      out_res_r <= res;
    end
  end

  // result ports
  assign out_valid       = out_valid_r;
  assign out_result_kind = out_res_r.kind;
  assign out_glyph       = out_res_r.glyph;
  assign out_pixel_x     = out_res_r.px;
  assign out_pixel_y     = out_res_r.py;
  assign out_fg_color    = out_res_r.fg;
  assign out_bg_color    = out_res_r.bg;
  assign out_last        = out_res_r.last;

endmodule

### rtl/tcce_checker.sv
// port-level assertions for the text console character engine, bound to the top level
module tcce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_result_kind,
  input logic [7:0]  out_glyph,
  input logic [13:0] out_pixel_x,
  input logic [12:0] out_pixel_y,
  input logic [31:0] out_fg_color,
  input logic [31:0] out_bg_color,
  input logic        out_last
);
  import tcce_pkg::*;

  // no result right after a reset cycle
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) && $stable(out_glyph)
      && $stable(out_pixel_x) && $stable(out_pixel_y) && $stable(out_fg_color)
      && $stable(out_bg_color) && $stable(out_last))
    else $error("stalled result changed");

  // scroll results carry no glyph and no position
  a_scroll_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_SCROLL)
      |-> (out_glyph == 8'd0) && (out_pixel_x == 14'd0) && (out_pixel_y == 13'd0))
    else $error("scroll result with glyph or position");

  // bad escape results carry no position and always end their byte
  a_badesc_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_BADESC)
      |-> (out_pixel_x == 14'd0) && (out_pixel_y == 13'd0) && out_last)
    else $error("bad escape result malformed");

  // kind code three is never produced
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_kind != 2'd3))
    else $error("undefined result kind");

endmodule

bind text_console_char_engine_top tcce_checker u_tcce_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_kind (out_result_kind),
  .out_glyph       (out_glyph),
  .out_pixel_x     (out_pixel_x),
  .out_pixel_y     (out_pixel_y),
  .out_fg_color    (out_fg_color),
  .out_bg_color    (out_bg_color),
  .out_last        (out_last)
);

### tb/sv/text_console_char_engine_top_tb.sv
// self-checking testbench for the text console character engine top level
`timescale 1ns / 1ps

module text_console_char_engine_top_tb;
  import tcce_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [3:0]  REG_SPARE     = 4'd12;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  in_char_code = 8'd0;
  logic        out_ready    = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic [3:0]  cfg_index    = 4'd0;
  logic [31:0] cfg_data     = 32'd0;

  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_glyph;
  logic [13:0] out_pixel_x;
  logic [12:0] out_pixel_y;
  logic [31:0] out_fg_color;
  logic [31:0] out_bg_color;
  logic        out_last;
  logic        cfg_ready;

  text_console_char_engine_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_glyph       (out_glyph),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_fg_color    (out_fg_color),
    .out_bg_color    (out_bg_color),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // console shadow: screen settings and cursor / color state
  cfg_t        scr;
  int unsigned cur_col;
  int unsigned cur_row;
  logic [31:0] cur_fg;
  logic [31:0] cur_bg;
  bit          in_escape;
  bit          edit_bg_sel;
  int unsigned step_count;

  result_t     predicted_results[$];
  logic [7:0]  pending_chars[$];

  // run bookkeeping
  int unsigned chars_queued   = 0;
  int unsigned bytes_taken    = 0;
  int unsigned settings_used  = 1;
  int unsigned draws_seen     = 0;
  int unsigned scrolls_seen   = 0;
  int unsigned bad_esc_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;

  // flow control state
  logic        in_acc      = 1'b0;
  bit          calm        = 1'b0;
  bit          hold_req    = 1'b0;
  logic        hold_on     = 1'b0;
  int unsigned hold_count  = 0;
  int unsigned send_gap    = 0;
  int unsigned recv_gap    = 0;

  // register write into the shadow settings
  task automatic apply_cfg(input logic [3:0] idx, input logic [31:0] d);
    case (idx)
      REG_TEXT_COLUMNS: scr.text_columns = d[9:0];
      REG_TEXT_ROWS:    scr.text_rows    = d[8:0];
      REG_GLYPH_WIDTH:  scr.glyph_width  = d[5:0];
      REG_GLYPH_HEIGHT: scr.glyph_height = d[5:0];
      REG_MARGIN_X:     scr.margin_x     = d[4:0];
      REG_MARGIN_Y:     scr.margin_y     = d[4:0];
      REG_DEFAULT_FG:   scr.default_fg   = d;
      REG_DEFAULT_BG:   scr.default_bg   = d;
      default: ;
    endcase
  endtask

  // one predicted result, dropped beyond the per-byte limit
  task automatic add_result(input kind_t k, input logic [7:0] g,
                            input int unsigned px, input int unsigned py);
    result_t r;
    if (step_count < MAX_RESULTS) begin
      r.kind  = k;
      r.glyph = g;
      r.px    = px[13:0];
      r.py    = py[12:0];
      r.fg    = cur_fg;
      r.bg    = cur_bg;
      r.last  = 1'b0;
      predicted_results.push_back(r);
      step_count++;
    end
  endtask

  // byte outside escape mode (tab already expanded)
  task automatic plain_byte(input logic [7:0] c);
    int unsigned px;
    int unsigned py;
    px = cur_col * 32'(scr.glyph_width) + 32'(scr.margin_x);
    py = cur_row * 32'(scr.glyph_height) + 32'(scr.margin_y);
    case (c)
      CH_LF: begin
        cur_col = 0;
        cur_row++;
      end
      CH_CR: cur_col = 0;
      CH_BS: begin
        if (cur_col == 0) begin
          // back to the end of the row above, except on the top row
          if (cur_row != 0) begin
            cur_col = (32'(scr.text_columns) - 32'd1) & 32'h3FF;
            cur_row--;
          end
        end else begin
          cur_col--;
        end
      end
      CH_ESC: begin
        in_escape = 1'b1;
        return;
      end
      default: begin
        add_result(KIND_DRAW, c, px, py);
        cur_col++;
      end
    endcase
    // column wrap, then scroll when the row runs off the bottom
    if (cur_col >= 32'(scr.text_columns)) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= 32'(scr.text_rows)) begin
      add_result(KIND_SCROLL, 8'd0, 0, 0);
      cur_row = (scr.text_rows != 9'd0) ? 32'(scr.text_rows) - 32'd1 : 32'd0;
    end
    cur_col &= 32'h3FF;
    cur_row &= 32'h1FF;
  endtask

  // byte inside escape mode
  task automatic escape_byte(input logic [7:0] c);
    logic [7:0] nib8;
    bit         is_hex;
    if (c == CH_ESC) begin
      in_escape = 1'b0;
    end else if (c == CH_LOWER_F) begin
      edit_bg_sel = 1'b0;
      cur_fg      = 32'd0;
    end else if (c == CH_LOWER_B) begin
      edit_bg_sel = 1'b1;
      cur_bg      = 32'd0;
    end else begin
      is_hex = 1'b1;
      nib8   = 8'd0;
      if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) nib8 = c - CH_DIGIT_0;
      else if (c >= CH_UPPER_A && c <= CH_UPPER_F) nib8 = c - HEX_ALPHA_BASE;
      else is_hex = 1'b0;
      if (is_hex) begin
        if (edit_bg_sel) cur_bg = {cur_bg[27:0], nib8[3:0]};
        else cur_fg = {cur_fg[27:0], nib8[3:0]};
      end else begin
        // bad escape byte: restore the color being edited
        if (edit_bg_sel) cur_bg = scr.default_bg;
        else cur_fg = scr.default_fg;
        in_escape = 1'b0;
        add_result(KIND_BADESC, c, 0, 0);
      end
    end
  endtask

  // expected results of one accepted byte
  task automatic console_step(input logic [7:0] c);
    result_t r;
    step_count = 0;
    if (in_escape) escape_byte(c);
    else if (c == CH_TAB) repeat (TAB_SPACES_DEF) plain_byte(CH_SPACE);
    else plain_byte(c);
    if (step_count > 0) begin
      r = predicted_results.pop_back();
      r.last = 1'b1;
      predicted_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare one result transaction with the oldest prediction
  task automatic check_result();
    result_t want;
    if (predicted_results.size() == 0) begin
      $display("%0t: unexpected result, kind %0d glyph %0h", $time, out_result_kind,
               out_glyph);
      mismatches++;
    end else begin
      want = predicted_results.pop_front();
      check_field("result_kind", 32'(want.kind), 32'(out_result_kind));
      check_field("glyph", 32'(want.glyph), 32'(out_glyph));
      check_field("pixel_x", 32'(want.px), 32'(out_pixel_x));
      check_field("pixel_y", 32'(want.py), 32'(out_pixel_y));
      check_field("fg_color", want.fg, out_fg_color);
      check_field("bg_color", want.bg, out_bg_color);
      check_field("last", 32'(want.last), 32'(out_last));
      case (want.kind)
        KIND_DRAW:   draws_seen++;
        KIND_SCROLL: scrolls_seen++;
        default:     bad_esc_seen++;
      endcase
    end
  endtask

  // monitor: config writes, accepted bytes and result transactions
  always @(posedge clk) begin
    in_acc <= in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        console_step(in_char_code);
        bytes_taken++;
      end
      if (out_valid && out_ready) check_result();
    end
  end

  // driver: feeds pending bytes with random gaps
  always @(negedge clk) begin
    if (!in_valid || in_acc) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!rst_n || pending_chars.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 14);
      end else begin
        in_valid     <= 1'b1;
        in_char_code <= pending_chars.pop_front();
      end
    end
  end

  // receiver: random stalls, plus the long hold-off
  always @(negedge clk) begin
    if (hold_on) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      out_ready <= 1'b0;
      recv_gap  <= recv_gap - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      recv_gap  <= $urandom_range(0, 14);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // long hold-off, counted once
  always @(posedge clk) begin
    if (hold_on) begin
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) hold_on <= 1'b0;
    end else if (hold_req && hold_count == 0) begin
      hold_on <= 1'b1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               predicted_results.size());
      $display("text_console_char_engine_top: mismatch");
      $finish;
    end
  end

  task automatic queue_char(input logic [7:0] c);
    pending_chars.push_back(c);
    chars_queued++;
  endtask

  // one config write transaction, unused upper data bits randomized
  task automatic write_reg(input logic [3:0] idx, input logic [31:0] val,
                           input int unsigned width);
    logic [63:0] keep;
    logic [31:0] d;
    keep = (64'd1 << width) - 64'd1;
    d    = ($urandom() & ~keep[31:0]) | (val & keep[31:0]);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_screen(input int unsigned tc, input int unsigned tr,
                            input int unsigned gw, input int unsigned gh,
                            input int unsigned mx, input int unsigned my,
                            input logic [31:0] dfg, input logic [31:0] dbg);
    write_reg(REG_TEXT_COLUMNS, tc, 10);
    write_reg(REG_TEXT_ROWS, tr, 9);
    write_reg(REG_GLYPH_WIDTH, gw, 6);
    write_reg(REG_GLYPH_HEIGHT, gh, 6);
    write_reg(REG_MARGIN_X, mx, 5);
    write_reg(REG_MARGIN_Y, my, 5);
    write_reg(REG_DEFAULT_FG, dfg, 32);
    write_reg(REG_DEFAULT_BG, dbg, 32);
    settings_used++;
    @(posedge clk);
  endtask

  // wait for all bytes taken and all results checked, then let the engine settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_chars.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random console text: mostly well-formed escape sequences, control bytes and glyphs
  task automatic queue_text(input int unsigned count, input int unsigned lf_pct,
                            input int unsigned tab_pct);
    int unsigned goal;
    int unsigned r;
    int unsigned nib;
    goal = chars_queued + count;
    while (chars_queued < goal) begin
      r = $urandom_range(0, 99);
      if (r < lf_pct) begin
        queue_char(CH_LF);
      end else if (r < lf_pct + tab_pct) begin
        queue_char(CH_TAB);
      end else if (r < lf_pct + tab_pct + 10) begin
        queue_char(($urandom_range(0, 1) == 0) ? CH_BS : CH_CR);
      end else if (r < lf_pct + tab_pct + 35) begin
        queue_char(CH_ESC);
        if ($urandom_range(0, 4) != 0)
          queue_char(($urandom_range(0, 1) == 0) ? CH_LOWER_F : CH_LOWER_B);
        repeat ($urandom_range(0, 9)) begin
          nib = $urandom_range(0, 15);
          queue_char((nib < 10) ? CH_DIGIT_0 + 8'(nib) : HEX_ALPHA_BASE + 8'(nib));
        end
        // mostly a clean close, sometimes a stray byte
        if ($urandom_range(0, 9) < 7) queue_char(CH_ESC);
        else queue_char(8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 1) == 0) begin
        queue_char(8'($urandom_range(8'h20, 8'h7E)));
      end else begin
        queue_char(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // stimulus sequence
  initial begin
    scr         = CFG_RESET;
    cur_col     = 0;
    cur_row     = 0;
    cur_fg      = CFG_RESET.default_fg;
    cur_bg      = CFG_RESET.default_bg;
    in_escape   = 1'b0;
    edit_bg_sel = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, cursor moves, tab, good and bad escapes
    queue_char(CH_UPPER_A);
    queue_char(8'h00);
    queue_char(8'hFF);
    queue_char(CH_BS);
    queue_char(CH_CR);
    queue_char(CH_BS);
    queue_char(CH_LF);
    queue_char(CH_BS);
    queue_char(8'h7E);
    queue_char(CH_TAB);
    queue_char(CH_ESC);
    queue_char(CH_LOWER_F);
    queue_char(CH_DIGIT_0 + 8'd1);
    queue_char(CH_UPPER_A);
    queue_char(CH_DIGIT_9);
    queue_char(CH_UPPER_F);
    queue_char(CH_ESC);
    queue_char("x");
    queue_char(CH_ESC);
    queue_char(CH_LOWER_B);
    queue_char(CH_DIGIT_0);
    queue_char("Z");
    queue_char(CH_ESC);
    queue_char("q");
    wait_idle();

    // tiny screen: constant wraps and scrolls, tabs cross rows
    set_screen(3, 2, 1, 1, 0, 0, $urandom(), $urandom());
    write_reg(REG_SPARE, $urandom(), 32);
    queue_text(120, 10, 10);
    wait_idle();

    // zero columns and rows, zero cell size
    set_screen(0, 0, 0, 0, 17, 9, $urandom(), $urandom());
    queue_text(40, 10, 10);
    wait_idle();

    // full field widths: pixel coordinates wrap deep in the screen
    set_screen(1023, 511, 63, 63, 31, 31, $urandom(), $urandom());
    queue_text(200, 75, 2);
    wait_idle();

    // largest normal screen with the output held off for a long stretch
    set_screen(512, 256, 32, 32, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    hold_req <= 1'b1;
    queue_text(60, 10, 25);
    wait_idle();

    // closing stretch without idling on either side, rows shrink under the cursor
    calm <= 1'b1;
    set_screen(5, 4, 8, 16, 1, 1, $urandom(), $urandom());
    queue_text(80, 10, 10);
    wait_idle();
    repeat (20) @(posedge clk);

    $display("covered %0d bytes over %0d screen settings: %0d draws, %0d scrolls, %0d bad escapes",
             bytes_taken, settings_used, draws_seen, scrolls_seen, bad_esc_seen);
    $display("output held off once for %0d cycles; %0d field mismatches", HOLD_CYCLES,
             mismatches);
    if (mismatches == 0) begin
      $display("text_console_char_engine_top: match");
    end else begin
      $display("text_console_char_engine_top: mismatch");
    end
    $finish;
  end

endmodule
